// ----- rtl/core/sle_pkg.sv -----
package sle_pkg;

	// List geometry.
	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;
	localparam int INDEX_BITS = 5;
	localparam int CMD_BITS   = 3;

	localparam int POS_BITS   = $clog2(CAPACITY);
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);
	localparam int PLACE_BITS = $clog2(CAPACITY + 2) + 1;

	// Common width for comparing the request index against the entry count.
	localparam int CMP_BITS = (INDEX_BITS > COUNT_BITS) ? INDEX_BITS : COUNT_BITS;

	// Stream word widths, padded to whole bytes.
	localparam int S_TDATA_W = ((VALUE_BITS + INDEX_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W = ((PLACE_BITS + VALUE_BITS + COUNT_BITS + 7) / 8) * 8;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_INSERT    = 3'd0;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE    = 3'd1;
	localparam logic [CMD_BITS-1:0] CMD_FIND      = 3'd2;
	localparam logic [CMD_BITS-1:0] CMD_READ_AT   = 3'd3;
	localparam logic [CMD_BITS-1:0] CMD_REMOVE_AT = 3'd4;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd5;

	// Per-cell update operations.
	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_INSERT = 2'd1;
	localparam logic [1:0] CELL_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]            op;
		logic                  by_index;
		logic [POS_BITS-1:0]   idx0;
		logic [VALUE_BITS-1:0] key;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/sorted_list_engine.sv -----
// A command accepted at one edge has its result word registered on m_* in the next cycle.
// One command per cycle unless m_tready stalls; a result frees its register once taken.
// Every command finishes in one pass through the row of compare-and-shift cells.
// Reset (arst_n low, asynchronous): the list count clears to zero and no result is pending.
// Stored entries are not cleared; only entries below the count are ever read.
module sorted_list_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// Command words.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [sle_pkg::S_TDATA_W-1:0] s_tdata,  // value, index, zero pad
	input  logic [sle_pkg::CMD_BITS-1:0]  s_tuser,  // cmd
	// Result words.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sle_pkg::M_TDATA_W-1:0] m_tdata,  // place, entry, count, zero pad
	output logic [0:0]                    m_tuser   // ok
);
	import sle_pkg::*;

	// Unpacked command fields.
	logic [CMD_BITS-1:0]   cmd;
	logic [VALUE_BITS-1:0] value;
	logic [INDEX_BITS-1:0] index;
	logic                  accept;

	// Cell row.
	cell_ctrl_t            ctrl;
	logic [VALUE_BITS-1:0] slot_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_lt;
	logic [CAPACITY-1:0]   cell_first;
	logic [CAPACITY-1:0]   cell_hit;

	// Search and decode results.
	logic                  found;
	logic                  any_first;
	logic [COUNT_BITS-1:0] pos0;
	logic [PLACE_BITS-1:0] pos1;
	logic [PLACE_BITS-1:0] search_place;
	logic [CMP_BITS-1:0]   idx_ext;
	logic [CMP_BITS-1:0]   fill_ext;
	logic                  idx_ok;
	logic [POS_BITS-1:0]   idx0;

	// Next result and next count.
	logic                  ok_d;
	logic [PLACE_BITS-1:0] place_d;
	logic [VALUE_BITS-1:0] entry_d;
	logic [COUNT_BITS-1:0] fill_d;

	// State and output registers.
	logic [COUNT_BITS-1:0] fill_q;
	logic                  out_valid_q;
	logic                  ok_q;
	logic [PLACE_BITS-1:0] place_q;
	logic [VALUE_BITS-1:0] entry_q;
	logic [COUNT_BITS-1:0] count_q;

	assign cmd    = s_tuser;
	assign value  = s_tdata[VALUE_BITS-1:0];
	assign index  = s_tdata[VALUE_BITS +: INDEX_BITS];

	// A new command is taken whenever the result register is empty or is being
	// drained in the same cycle, so a full output never stalls a free pipeline.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Each cell compares the key with its own entry. Because the list is sorted,
	// the "key is greater" flags form a run from cell 0, and the first cell
	// outside that run is the insertion point. A cell flags a hit when the
	// insertion point lands on an entry equal to the key.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_data;
		logic [VALUE_BITS-1:0] right_data;
		logic                  left_lt;

		if (i == 0) begin : g_head
			assign left_data = value;
			assign left_lt   = 1'b1;
		end else begin : g_body
			assign left_data = slot_data[i-1];
			assign left_lt   = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_data = slot_data[i];
		end else begin : g_mid
			assign right_data = slot_data[i+1];
		end

		sle_cell u_cell (
			.clk        (clk),
			.pos        (POS_BITS'(i)),
			.fill       (fill_q),
			.ctrl       (ctrl),
			.left_data  (left_data),
			.right_data (right_data),
			.left_lt    (left_lt),
			.data       (slot_data[i]),
			.lt         (cell_lt[i]),
			.first      (cell_first[i]),
			.hit        (cell_hit[i])
		);
	end

	// At most one cell is the insertion point, so its position is an OR over the
	// row. When no cell claims it, every cell holds a smaller entry and the list
	// is full, which puts the insertion point just past the last slot.
	always_comb begin
		pos0      = '0;
		any_first = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_first[i]) begin
				pos0 = pos0 | COUNT_BITS'(i);
			end
			any_first = any_first | cell_first[i];
		end
		if (!any_first) begin
			pos0 = COUNT_BITS'(CAPACITY);
		end
	end

	assign found        = |cell_hit;
	assign pos1         = PLACE_BITS'(pos0) + PLACE_BITS'(1);
	assign search_place = found ? pos1 : (-pos1);

	// Position-addressed commands: valid positions run from 1 up to the count.
	assign idx_ext  = CMP_BITS'(index);
	assign fill_ext = CMP_BITS'(fill_q);
	assign idx_ok   = (idx_ext != '0) && (idx_ext <= fill_ext);
	assign idx0     = POS_BITS'(idx_ext - CMP_BITS'(1));

	// Command decode: picks the row operation, the result fields and the new count.
	always_comb begin
		ctrl.op       = CELL_HOLD;
		ctrl.by_index = 1'b0;
		ctrl.idx0     = idx0;
		ctrl.key      = value;
		ok_d          = 1'b0;
		place_d       = '0;
		entry_d       = '0;
		fill_d        = fill_q;
		unique case (cmd)
			CMD_INSERT: begin
				place_d = search_place;
				if (fill_q < COUNT_BITS'(CAPACITY)) begin
					ctrl.op = CELL_INSERT;
					ok_d    = 1'b1;
					fill_d  = fill_q + COUNT_BITS'(1);
				end
			end
			CMD_REMOVE: begin
				place_d = search_place;
				if (found) begin
					ctrl.op = CELL_REMOVE;
					ok_d    = 1'b1;
					fill_d  = fill_q - COUNT_BITS'(1);
				end
			end
			CMD_FIND: begin
				place_d = search_place;
				ok_d    = found;
			end
			CMD_READ_AT, CMD_REMOVE_AT: begin
				if (idx_ok) begin
					ok_d    = 1'b1;
					place_d = PLACE_BITS'(index);
					entry_d = slot_data[idx0];
					if (cmd == CMD_REMOVE_AT) begin
						ctrl.op       = CELL_REMOVE;
						ctrl.by_index = 1'b1;
						fill_d        = fill_q - COUNT_BITS'(1);
					end
				end
			end
			CMD_CLEAR: begin
				ok_d   = 1'b1;
				fill_d = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		// The cells only move when a command is really taken.
		if (!accept) begin
			ctrl.op = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok_d;
			place_q <= place_d;
			entry_q <= entry_d;
			count_q <= fill_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = M_TDATA_W'({count_q, entry_q, place_q});

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= COUNT_BITS'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted command left no result");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (count_q == fill_q))
		else $error("reported count differs from list count");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (fill_q == $past(fill_q) || fill_q == '0 ||
			fill_q == $past(fill_q) + COUNT_BITS'(1) ||
			fill_q == $past(fill_q) - COUNT_BITS'(1)))
		else $error("entry count moved by more than one");

	a_fill_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(fill_q))
		else $error("entry count changed without a command");
`endif

endmodule

// ----- rtl/core/sle_cell.sv -----
module sle_cell (
	input  logic                           clk,
	input  logic [sle_pkg::POS_BITS-1:0]   pos,
	input  logic [sle_pkg::COUNT_BITS-1:0] fill,
	input  sle_pkg::cell_ctrl_t            ctrl,
	input  logic [sle_pkg::VALUE_BITS-1:0] left_data,
	input  logic [sle_pkg::VALUE_BITS-1:0] right_data,
	input  logic                           left_lt,
	output logic [sle_pkg::VALUE_BITS-1:0] data,
	output logic                           lt,
	output logic                           first,
	output logic                           hit
);
	import sle_pkg::*;

	logic [VALUE_BITS-1:0] data_q;
	logic [VALUE_BITS-1:0] data_d;
	logic                  active;
	logic                  after;

	// A cell only takes part in the search while it holds a live entry.
	assign active = COUNT_BITS'(pos) < fill;
	assign lt     = active && (ctrl.key > data_q);
	assign first  = !lt && left_lt;
	assign hit    = first && active && (ctrl.key == data_q);
	assign after  = ctrl.by_index ? (pos >= ctrl.idx0) : !lt;
	assign data   = data_q;

	always_comb begin
		data_d = data_q;
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (first) begin
					data_d = ctrl.key;
				end else if (!lt) begin
					data_d = left_data;
				end
			end
			CELL_REMOVE: begin
				if (after) begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule
